// ===== rtl/core/alternating_decimal_display_formatter_defines.svh =====
// Assertion macros shared by the alternating decimal display formatter RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef ALTERNATING_DECIMAL_DISPLAY_FORMATTER_DEFINES_SVH
`define ALTERNATING_DECIMAL_DISPLAY_FORMATTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADDF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ADDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/addf_pkg.sv =====
// Shared types, constants and the divide-by-ten helper for the display formatter.
// No dependencies; used by every module of the block.
package addf_pkg;

   localparam int DISPLAY_DIGITS_DEF = 8;
   localparam int VALUE_W            = 32;
   localparam int DIGIT_W            = 4;
   localparam int POS_W              = 3;
   localparam int BYTE_W             = 8;

   // Reciprocal constants for exact floor division of any 32-bit value
   localparam logic [VALUE_W-1:0] RECIP_3  = 32'hAAAA_AAAB;
   localparam int                 SHIFT_3  = 33;
   localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int                 SHIFT_10 = 35;
   localparam logic [VALUE_W-1:0] ROUND_HALF = 32'd5;
   localparam logic [BYTE_W-1:0]  BYTE_RESET = 8'hFF;

   typedef enum logic [1:0] {
      ACT_LOAD_FREQ = 2'd0,
      ACT_LOAD_ACT  = 2'd1,
      ACT_TICK      = 2'd2
   } action_type;

   // Per-stage control that travels with each tick
   typedef struct packed {
      logic valid;
      logic dot;
   } tick_ctl_type;

   // Floor of v / 10 by reciprocal multiply
   function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] v);
      logic [2*VALUE_W-1:0] prod;
      begin
         prod = (2*VALUE_W)'(v) * (2*VALUE_W)'(RECIP_10);
         return VALUE_W'(prod >> SHIFT_10);
      end
   endfunction

endpackage

// ===== rtl/core/alternating_decimal_display_formatter.sv =====
// Top level of the alternating decimal display formatter.
// Depends on addf_pkg, addf_scale, addf_cell and addf_ser.
//
//   channel | direction | handshake            | fields
//   req     | in        | req_valid/req_stall  | action, byte_index, byte_value
//   rsp     | out       | rsp_valid/rsp_stall  | digit_value, digit_position,
//           |           |                      | decimal_point, last_digit
//
// Loads produce no output; a tick yields DISPLAY_DIGITS items. The output serializer
// takes a new tick's digits as the last digit of the current run is taken. The first
// digit shows after capture, two scaling stages, one cell per digit and the serializer
// register. Synchronous reset loads all bytes with 0xff and shows frequency first.
// Output stalls back up through the cells; req_stall rises only once every stage
// holds a tick.
module alternating_decimal_display_formatter #(
   parameter int DISPLAY_DIGITS = addf_pkg::DISPLAY_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [1:0] req_byte_index,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_digit_value,
   output logic [2:0] rsp_digit_position,
   output logic       rsp_decimal_point,
   output logic       rsp_last_digit
);
   import addf_pkg::*;

   localparam int DIG_VEC_W = DIGIT_W * DISPLAY_DIGITS;

   tick_ctl_type          chain_ctl [DISPLAY_DIGITS+1];
   logic [VALUE_W-1:0]    chain_val [DISPLAY_DIGITS+1];
   logic [DIG_VEC_W-1:0]  chain_dig [DISPLAY_DIGITS+1];
   logic                  chain_free[DISPLAY_DIGITS+1];

   // Scaling front end feeds the head of the cell row
   addf_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_byte_index (req_byte_index),
      .req_byte_value (req_byte_value),
      .out_ctl        (chain_ctl[0]),
      .out_value      (chain_val[0]),
      .out_free       (chain_free[0])
   );

   assign chain_dig[0] = '0;

   // Row of digit cells, one per display position
   generate
      for (genvar i = 0; i < DISPLAY_DIGITS; i++) begin : g_cell
         addf_cell #(
            .DIGITS (DISPLAY_DIGITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_ctl     (chain_ctl[i]),
            .in_value   (chain_val[i]),
            .in_digits  (chain_dig[i]),
            .in_free    (chain_free[i]),
            .out_ctl    (chain_ctl[i+1]),
            .out_value  (chain_val[i+1]),
            .out_digits (chain_dig[i+1]),
            .out_free   (chain_free[i+1])
         );
      end
   endgenerate

   // Serialize finished digit sets onto the result channel
   addf_ser #(
      .DIGITS (DISPLAY_DIGITS)
   ) u_ser (
      .clock              (clock),
      .reset              (reset),
      .in_ctl             (chain_ctl[DISPLAY_DIGITS]),
      .in_digits          (chain_dig[DISPLAY_DIGITS]),
      .in_free            (chain_free[DISPLAY_DIGITS]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_value    (rsp_digit_value),
      .rsp_digit_position (rsp_digit_position),
      .rsp_decimal_point  (rsp_decimal_point),
      .rsp_last_digit     (rsp_last_digit)
   );

endmodule

// ===== rtl/core/addf_scale.sv =====
// Input side: byte stores, alternation flag and the activity scaling stages.
// Depends on addf_pkg.
module addf_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [1:0]                      req_byte_index,
   input  logic [7:0]                      req_byte_value,
   output addf_pkg::tick_ctl_type          out_ctl,
   output logic [addf_pkg::VALUE_W-1:0]    out_value,
   input  logic                            out_free
);
   import addf_pkg::*;

   logic [VALUE_W-1:0]   freq_ff, freq_in;
   logic [VALUE_W-1:0]   act_ff, act_in;
   logic                 show_act_ff, show_act_in;
   tick_ctl_type         s0_ctl_ff, s0_ctl_in, s1_ctl_ff, s1_ctl_in, s2_ctl_ff, s2_ctl_in;
   logic [VALUE_W-1:0]   s0_val_ff, s0_val_in, s1_val_ff, s1_val_in, s2_val_ff, s2_val_in;
   logic [2*VALUE_W-1:0] prod3;
   logic                 free0, free1, free2;
   logic                 accept, tick;
   logic [4:0]           lane;

   // Stage handshake: a stage takes new data when empty or emptying
   always_comb begin
      free2     = !s2_ctl_ff.valid || out_free;
      free1     = !s1_ctl_ff.valid || free2;
      free0     = !s0_ctl_ff.valid || free1;
      req_stall = !free0;
      accept    = req_valid && free0;
      tick      = accept && (req_action == ACT_TICK);
      lane      = {req_byte_index, 3'b000};
   end

   // Store load bytes and toggle the value choice on each tick
   always_comb begin
      freq_in     = freq_ff;
      act_in      = act_ff;
      show_act_in = show_act_ff ^ tick;
      if (accept) begin
         case (req_action)
            ACT_LOAD_FREQ: freq_in[lane +: BYTE_W] = req_byte_value;
            ACT_LOAD_ACT:  act_in[lane +: BYTE_W]  = req_byte_value;
            default:       ;
         endcase
      end
   end

   // Capture, then for activity divide by three with the rounding bias and by ten; frequency passes
   always_comb begin
      prod3     = (2*VALUE_W)'(s0_val_ff) * (2*VALUE_W)'(RECIP_3);
      s0_ctl_in = s0_ctl_ff;
      s0_val_in = s0_val_ff;
      s1_ctl_in = s1_ctl_ff;
      s1_val_in = s1_val_ff;
      s2_ctl_in = s2_ctl_ff;
      s2_val_in = s2_val_ff;
      if (free0) begin
         s0_ctl_in.valid = tick;
         s0_ctl_in.dot   = show_act_ff;
         s0_val_in       = show_act_ff ? act_ff : freq_ff;
      end
      if (free1) begin
         s1_ctl_in = s0_ctl_ff;
         s1_val_in = s0_ctl_ff.dot ? (VALUE_W'(prod3 >> SHIFT_3) + ROUND_HALF) : s0_val_ff;
      end
      if (free2) begin
         s2_ctl_in = s1_ctl_ff;
         s2_val_in = s1_ctl_ff.dot ? div10(s1_val_ff) : s1_val_ff;
      end
   end

   // Hold control state and byte stores
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff     <= {4{BYTE_RESET}};
         act_ff      <= {4{BYTE_RESET}};
         show_act_ff <= 1'b0;
         s0_ctl_ff   <= '0;
         s1_ctl_ff   <= '0;
         s2_ctl_ff   <= '0;
      end else begin
         freq_ff     <= freq_in;
         act_ff      <= act_in;
         show_act_ff <= show_act_in;
         s0_ctl_ff   <= s0_ctl_in;
         s1_ctl_ff   <= s1_ctl_in;
         s2_ctl_ff   <= s2_ctl_in;
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      s0_val_ff <= s0_val_in;
      s1_val_ff <= s1_val_in;
      s2_val_ff <= s2_val_in;
   end

   assign out_ctl   = s2_ctl_ff;
   assign out_value = s2_val_ff;

endmodule

// ===== rtl/core/addf_cell.sv =====
// One digit cell: peels the low decimal digit off the value and passes the quotient on.
// Depends on addf_pkg.
module addf_cell #(
   parameter int DIGITS = addf_pkg::DISPLAY_DIGITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  addf_pkg::tick_ctl_type                in_ctl,
   input  logic [addf_pkg::VALUE_W-1:0]          in_value,
   input  logic [addf_pkg::DIGIT_W*DIGITS-1:0]   in_digits,
   output logic                                  in_free,
   output addf_pkg::tick_ctl_type                out_ctl,
   output logic [addf_pkg::VALUE_W-1:0]          out_value,
   output logic [addf_pkg::DIGIT_W*DIGITS-1:0]   out_digits,
   input  logic                                  out_free
);
   import addf_pkg::*;

   localparam int DIG_VEC_W = DIGIT_W * DIGITS;

   tick_ctl_type           ctl_ff, ctl_in;
   logic [VALUE_W-1:0]     val_ff, val_in;
   logic [DIG_VEC_W-1:0]   dig_ff, dig_in, dig_shifted;
   logic [VALUE_W-1:0]     quot;
   logic [DIGIT_W-1:0]     quot_x10, digit;

   // Split off the low digit: v - 10 * (v / 10), kept to four bits
   always_comb begin
      quot     = div10(in_value);
      quot_x10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};
      digit    = in_value[DIGIT_W-1:0] - quot_x10;
   end

   // Insert the new digit at the top so earlier digits drift toward the bottom
   generate
      if (DIGITS == 1) begin : g_single
         assign dig_shifted = digit;
      end else begin : g_multi
         assign dig_shifted = {digit, in_digits[DIG_VEC_W-1:DIGIT_W]};
      end
   endgenerate

   always_comb begin
      in_free = !ctl_ff.valid || out_free;
      ctl_in  = ctl_ff;
      val_in  = val_ff;
      dig_in  = dig_ff;
      if (in_free) begin
         ctl_in = in_ctl;
         val_in = quot;
         dig_in = dig_shifted;
      end
   end

   // Hold cell control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // Advance cell payload
   always_ff @(posedge clock) begin
      val_ff <= val_in;
      dig_ff <= dig_in;
   end

   assign out_ctl    = ctl_ff;
   assign out_value  = val_ff;
   assign out_digits = dig_ff;

endmodule

// ===== rtl/core/addf_ser.sv =====
// Output serializer: emits one digit item per cycle from a finished digit set while rsp_stall is low.
// Depends on addf_pkg and the shared assertion macro header.
`include "alternating_decimal_display_formatter_defines.svh"

module addf_ser #(
   parameter int DIGITS = addf_pkg::DISPLAY_DIGITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  addf_pkg::tick_ctl_type                in_ctl,
   input  logic [addf_pkg::DIGIT_W*DIGITS-1:0]   in_digits,
   output logic                                  in_free,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [3:0]                            rsp_digit_value,
   output logic [2:0]                            rsp_digit_position,
   output logic                                  rsp_decimal_point,
   output logic                                  rsp_last_digit
);
   import addf_pkg::*;

   localparam int DIG_VEC_W = DIGIT_W * DIGITS;
   localparam int CNT_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

   logic                  busy_ff, busy_in;
   logic                  dot_ff, dot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIG_VEC_W-1:0]  dig_ff, dig_in;
   logic [CNT_W+POS_W-1:0] cnt_ext;
   logic                  last, take, done;

   always_comb begin
      last    = (cnt_ff == CNT_LAST);
      take    = busy_ff && !rsp_stall;
      done    = take && last;
      in_free = !busy_ff || done;
   end

   // Load a new digit set, step through digits, drop when the run ends
   always_comb begin
      busy_in = busy_ff;
      dot_in  = dot_ff;
      cnt_in  = cnt_ff;
      dig_in  = dig_ff;
      if (in_free && in_ctl.valid) begin
         busy_in = 1'b1;
         dot_in  = in_ctl.dot;
         cnt_in  = '0;
         dig_in  = in_digits;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (take) begin
         cnt_in = cnt_ff + CNT_W'(1);
         dig_in = dig_ff >> DIGIT_W;
      end
   end

   // Hold run state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Hold digit payload
   always_ff @(posedge clock) begin
      dot_ff <= dot_in;
      dig_ff <= dig_in;
   end

   assign cnt_ext            = {{POS_W{1'b0}}, cnt_ff};
   assign rsp_valid          = busy_ff;
   assign rsp_digit_value    = dig_ff[DIGIT_W-1:0];
   assign rsp_digit_position = cnt_ext[POS_W-1:0];
   assign rsp_last_digit     = last;
   assign rsp_decimal_point  = dot_ff && last;

   `ADDF_ASSERT_NOW(a_digit_decimal, rsp_valid, rsp_digit_value <= 4'd9, "digit above nine")
   `ADDF_ASSERT_NEXT(a_pos_advance, take && !last, busy_ff && (cnt_ff == $past(cnt_ff) + CNT_W'(1)), "position did not advance")
   `ADDF_ASSERT_NEXT(a_run_end, done && !in_ctl.valid, !busy_ff, "run did not end after last digit")
   `ADDF_ASSERT_NEXT(a_run_start, in_free && in_ctl.valid, busy_ff && (cnt_ff == '0), "new run did not start at position zero")

endmodule
